### rtl/core/pcbs_pkg.sv
// ============================================================================
// pcbs_pkg
// Shared types, constants and saturating helpers for the periodic cubic
// B-spline coefficient solver.
// ============================================================================
package pcbs_pkg;

  localparam int MAX_POINTS_DEF = 1024;
  localparam int VAL_W          = 48;    // internal value width
  localparam int COEF_W         = 32;    // coefficient width
  localparam int IDX_W          = 11;    // index and count field width
  localparam int CF             = 30;    // fraction bits of gamma, mu, 1/diag
  localparam int RECIP_STEPS    = 2 * CF + 1;

  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [COEF_W-1:0] word_t;

  localparam val_t MAX48       = 48'sh7FFF_FFFF_FFFF;
  localparam val_t MIN48       = 48'sh8000_0000_0000;
  localparam val_t K_ONE       = 48'sh0000_4000_0000;
  localparam val_t K_RATIO     = 48'sh0000_1000_0000;
  localparam val_t K_NEG_RATIO = 48'shFFFF_F000_0000;
  localparam val_t K_3HALF     = 48'sh0000_6000_0000;

  // item kind on tuser
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // register selects (paddr[2])
  localparam logic REG_INTERPOLATE  = 1'b0;
  localparam logic REG_SAMPLE_COUNT = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CP_RD, S_CP_WR,
    S_IN_RD0, S_IN_S0, S_IN_W0, S_IN_RDL, S_IN_SL,
    S_F_RD, S_F_M0, S_F_M1, S_F_DIV, S_F_M2, S_F_M3, S_F_M4,
    S_F_M5, S_F_M6, S_F_M7, S_F_M8, S_F_M9,
    S_P_A, S_P_M1, S_P_M2, S_P_DIV, S_P_M3,
    S_B_RD, S_B_M1, S_B_M2,
    S_W0, S_W1, S_W2
  } state_t;

  function automatic val_t add_sat48(input val_t a, input val_t b);
    logic signed [VAL_W:0] s;
    s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    if (s[VAL_W] != s[VAL_W-1]) return s[VAL_W] ? MIN48 : MAX48;
    return s[VAL_W-1:0];
  endfunction

  function automatic val_t sub_sat48(input val_t a, input val_t b);
    logic signed [VAL_W:0] s;
    s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
    if (s[VAL_W] != s[VAL_W-1]) return s[VAL_W] ? MIN48 : MAX48;
    return s[VAL_W-1:0];
  endfunction

  function automatic word_t sat32(input val_t v);
    if (!((&v[VAL_W-1:COEF_W-1]) || (~|v[VAL_W-1:COEF_W-1])))
      return v[VAL_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    return v[COEF_W-1:0];
  endfunction

  function automatic val_t sext32(input word_t w);
    return {{(VAL_W-COEF_W){w[COEF_W-1]}}, w};
  endfunction

endpackage

### rtl/core/periodic_cubic_bspline_solver.sv
// ============================================================================
// periodic_cubic_bspline_solver
// Read path: a read transaction passes the RAM read register, then the output
//   register; a load transaction is written straight into the rhs RAM.
// Throughput: one item per cycle while loading or reading, unless a held result
//   stalls s_axis_tready. The last sample of a set starts a solve (interpolating)
//   or a copy; the solve is paced by the shared multiplier and the 61-step divider.
// Reset: synchronous; interpolate=1, sample_count=16, no set loaded, not solved.
// ============================================================================
//
// Structure
//   Four synchronous RAMs hold the state: right sides (rhs), gamma, mu and the
//   coefficients. A sequencer walks the rows, reading an entry, running it
//   through the shared Q.30 multiplier and reciprocal units and writing back.
//   Values of the previous row and of the bordered last row are kept in
//   registers, so a row is always written before it is read again; no
//   forwarding is needed.
//
// Solve order (interpolating)
//   prelude : scale d[0] and d[n-1] by 1.5, seed g[0]=m[0]=0.25
//   forward : rows 1..n-2, one reciprocal and ten products a row
//   border  : close the last row, coefficient n = d/g
//   back    : rows n-2..0, two products a row
//   wrap    : P(0)=P(n), P(n+1)=P(1), P(n+2)=P(2)
//
// While a solve runs s_axis_tready is low; configuration writes are to be made
// only when the block is idle; the block itself does not enforce this.
module periodic_cubic_bspline_solver #(
  parameter int MAX_POINTS = pcbs_pkg::MAX_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [31:0] sample, [42:32] index, rest zero
  input  logic [0:0]  s_axis_tuser,   // [0] mode
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] coefficient
  output logic [1:0]  m_axis_tuser,   // [0] ready_res, [1] index_ok
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW     = $clog2(MAX_POINTS);
  localparam int CDEPTH = MAX_POINTS + 3;
  localparam int CW     = $clog2(CDEPTH);
  localparam int XW     = ((CW > pcbs_pkg::IDX_W) ? CW : pcbs_pkg::IDX_W) + 1;

  // ---------------------------------------------------------------------------
  // Registers and configuration
  // ---------------------------------------------------------------------------
  logic        interpolate;
  logic [10:0] sample_count;
  logic [CW-1:0] n, n_m1, n_m2, lc, lc_inc;
  logic [AW-1:0] nm1_a, row;
  logic        solved;
  logic        cfg_wr;

  pcbs_pkg::state_t state, state_next;
  logic        op_wait;

  // datapath registers
  pcbs_pkg::val_t pm, pg, pd, m_last, g_last, d_last;
  pcbs_pkg::val_t ds, tmp, inv, ng, nm, nd, prev;
  pcbs_pkg::word_t c1, c2, cn;

  // arithmetic units
  logic            mul_start, mul_done, div_start, div_done;
  pcbs_pkg::val_t  mul_a, mul_b, mul_y, div_x, div_y;

  // RAM ports
  logic            rhs_we, rhs_re, mg_re, sw_we;
  logic [AW-1:0]   rhs_waddr, rhs_raddr;
  pcbs_pkg::val_t  rhs_wdata, rhs_rdata, mu_rdata, g_rdata, sw_d, sw_m, sw_g;
  logic            cw_en, cf_re;
  logic [CW-1:0]   cw_addr, cf_raddr;
  pcbs_pkg::word_t cw_data;
  logic [31:0]     cf_rdata;

  // stream side
  logic            in_fire, load_fire, read_fire, last_sample, out_free;
  logic [XW-1:0]   idx_x;
  logic            q1_valid, q1_ok, q1_solved;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    if (paddr[2] == pcbs_pkg::REG_INTERPOLATE) prdata = {31'b0, interpolate};
    else                                       prdata = {21'b0, sample_count};
  end

  // clamp the sample count to [3, MAX_POINTS]
  always_comb begin
    if (sample_count < 11'd3)                n = CW'(3);
    else if (int'(sample_count) > MAX_POINTS) n = CW'(MAX_POINTS);
    else                                     n = CW'(sample_count);
  end

  assign n_m1   = n - CW'(1);
  assign n_m2   = n - CW'(2);
  assign nm1_a  = n_m1[AW-1:0];
  assign lc_inc = lc + CW'(1);
  assign last_sample = lc_inc >= n;

  // ---------------------------------------------------------------------------
  // Input and result handshake
  // ---------------------------------------------------------------------------
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == pcbs_pkg::S_IDLE) && !(q1_valid && !out_free);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign load_fire     = in_fire && (s_axis_tuser[0] == pcbs_pkg::MODE_LOAD);
  assign read_fire     = in_fire && (s_axis_tuser[0] == pcbs_pkg::MODE_READ);
  assign idx_x         = XW'(s_axis_tdata[42:32]);
  assign cf_re         = read_fire;
  assign cf_raddr      = idx_x[CW-1:0];

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      pcbs_pkg::S_IDLE:
        if (load_fire && last_sample)
          state_next = interpolate ? pcbs_pkg::S_IN_RD0 : pcbs_pkg::S_CP_RD;
      pcbs_pkg::S_CP_RD:  state_next = pcbs_pkg::S_CP_WR;
      pcbs_pkg::S_CP_WR:
        state_next = (row == nm1_a) ? pcbs_pkg::S_W0 : pcbs_pkg::S_CP_RD;
      pcbs_pkg::S_IN_RD0: state_next = pcbs_pkg::S_IN_S0;
      pcbs_pkg::S_IN_S0:  if (mul_done) state_next = pcbs_pkg::S_IN_W0;
      pcbs_pkg::S_IN_W0:  state_next = pcbs_pkg::S_IN_RDL;
      pcbs_pkg::S_IN_RDL: state_next = pcbs_pkg::S_IN_SL;
      pcbs_pkg::S_IN_SL:  if (mul_done) state_next = pcbs_pkg::S_F_RD;
      pcbs_pkg::S_F_RD:   state_next = pcbs_pkg::S_F_M0;
      pcbs_pkg::S_F_M0:   if (mul_done) state_next = pcbs_pkg::S_F_M1;
      pcbs_pkg::S_F_M1:   if (mul_done) state_next = pcbs_pkg::S_F_DIV;
      pcbs_pkg::S_F_DIV:  if (div_done) state_next = pcbs_pkg::S_F_M2;
      pcbs_pkg::S_F_M2:   if (mul_done) state_next = pcbs_pkg::S_F_M3;
      pcbs_pkg::S_F_M3:   if (mul_done) state_next = pcbs_pkg::S_F_M4;
      pcbs_pkg::S_F_M4:   if (mul_done) state_next = pcbs_pkg::S_F_M5;
      pcbs_pkg::S_F_M5:   if (mul_done) state_next = pcbs_pkg::S_F_M6;
      pcbs_pkg::S_F_M6:   if (mul_done) state_next = pcbs_pkg::S_F_M7;
      pcbs_pkg::S_F_M7:   if (mul_done) state_next = pcbs_pkg::S_F_M8;
      pcbs_pkg::S_F_M8:   if (mul_done) state_next = pcbs_pkg::S_F_M9;
      pcbs_pkg::S_F_M9:
        if (mul_done)
          state_next = ((row + AW'(1)) == nm1_a) ? pcbs_pkg::S_P_A : pcbs_pkg::S_F_RD;
      pcbs_pkg::S_P_A:    state_next = pcbs_pkg::S_P_M1;
      pcbs_pkg::S_P_M1:   if (mul_done) state_next = pcbs_pkg::S_P_M2;
      pcbs_pkg::S_P_M2:   if (mul_done) state_next = pcbs_pkg::S_P_DIV;
      pcbs_pkg::S_P_DIV:  if (div_done) state_next = pcbs_pkg::S_P_M3;
      pcbs_pkg::S_P_M3:   if (mul_done) state_next = pcbs_pkg::S_B_RD;
      pcbs_pkg::S_B_RD:   state_next = pcbs_pkg::S_B_M1;
      pcbs_pkg::S_B_M1:   if (mul_done) state_next = pcbs_pkg::S_B_M2;
      pcbs_pkg::S_B_M2:
        if (mul_done) state_next = (row == '0) ? pcbs_pkg::S_W0 : pcbs_pkg::S_B_RD;
      pcbs_pkg::S_W0:     state_next = pcbs_pkg::S_W1;
      pcbs_pkg::S_W1:     state_next = pcbs_pkg::S_W2;
      pcbs_pkg::S_W2:     state_next = pcbs_pkg::S_IDLE;
      default:            state_next = pcbs_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs (operand selection, RAM strobes)
  // ---------------------------------------------------------------------------
  logic mul_state, div_state;

  always_comb begin
    mul_state = 1'b0;
    div_state = 1'b0;
    mul_a     = pcbs_pkg::K_RATIO;
    mul_b     = pcbs_pkg::K_RATIO;
    div_x     = tmp;
    rhs_re    = 1'b0;
    rhs_raddr = row;
    mg_re     = 1'b0;
    sw_we     = 1'b0;
    sw_d      = nd;
    sw_m      = nm;
    sw_g      = ng;
    cw_en     = 1'b0;
    cw_addr   = CW'(row) + CW'(1);
    cw_data   = cn;
    case (state)
      pcbs_pkg::S_CP_RD:  rhs_re = 1'b1;
      pcbs_pkg::S_CP_WR: begin
        cw_en   = 1'b1;
        cw_data = pcbs_pkg::sat32(rhs_rdata);
      end
      pcbs_pkg::S_IN_RD0: rhs_re = 1'b1;
      pcbs_pkg::S_IN_S0: begin
        mul_state = 1'b1; mul_a = rhs_rdata; mul_b = pcbs_pkg::K_3HALF;
      end
      pcbs_pkg::S_IN_W0: begin
        sw_we = 1'b1; sw_d = pd; sw_m = pcbs_pkg::K_RATIO; sw_g = pcbs_pkg::K_RATIO;
      end
      pcbs_pkg::S_IN_RDL: begin
        rhs_re = 1'b1; rhs_raddr = nm1_a;
      end
      pcbs_pkg::S_IN_SL: begin
        mul_state = 1'b1; mul_a = rhs_rdata; mul_b = pcbs_pkg::K_3HALF;
      end
      pcbs_pkg::S_F_RD:   rhs_re = 1'b1;
      pcbs_pkg::S_F_M0: begin
        mul_state = 1'b1; mul_a = rhs_rdata; mul_b = pcbs_pkg::K_3HALF;
      end
      pcbs_pkg::S_F_M1: begin
        mul_state = 1'b1; mul_a = pm;
      end
      pcbs_pkg::S_F_DIV: begin
        div_state = 1'b1; div_x = tmp;
      end
      pcbs_pkg::S_F_M2: begin
        mul_state = 1'b1; mul_a = pcbs_pkg::K_NEG_RATIO; mul_b = pg;
      end
      pcbs_pkg::S_F_M3: begin
        mul_state = 1'b1; mul_a = tmp; mul_b = inv;
      end
      pcbs_pkg::S_F_M4: begin
        mul_state = 1'b1; mul_a = inv;
      end
      pcbs_pkg::S_F_M5: begin
        mul_state = 1'b1; mul_b = pd;
      end
      pcbs_pkg::S_F_M6: begin
        mul_state = 1'b1; mul_a = inv; mul_b = pcbs_pkg::sub_sat48(ds, tmp);
      end
      pcbs_pkg::S_F_M7: begin
        mul_state = 1'b1; mul_a = m_last; mul_b = pd;
      end
      pcbs_pkg::S_F_M8: begin
        mul_state = 1'b1; mul_a = m_last; mul_b = pg;
      end
      pcbs_pkg::S_F_M9: begin
        mul_state = 1'b1; mul_a = m_last; mul_b = pm;
        sw_we     = mul_done;
      end
      pcbs_pkg::S_P_M1: begin
        mul_state = 1'b1; mul_a = m_last; mul_b = pcbs_pkg::add_sat48(pm, pg);
      end
      pcbs_pkg::S_P_M2: begin
        mul_state = 1'b1; mul_a = m_last; mul_b = pd;
      end
      pcbs_pkg::S_P_DIV: begin
        div_state = 1'b1; div_x = g_last;
      end
      pcbs_pkg::S_P_M3: begin
        mul_state = 1'b1; mul_a = d_last; mul_b = inv;
        cw_en     = mul_done;
        cw_addr   = n;
        cw_data   = pcbs_pkg::sat32(mul_y);
      end
      pcbs_pkg::S_B_RD: begin
        rhs_re = 1'b1; mg_re = 1'b1;
      end
      pcbs_pkg::S_B_M1: begin
        mul_state = 1'b1; mul_a = mu_rdata; mul_b = prev;
      end
      pcbs_pkg::S_B_M2: begin
        mul_state = 1'b1; mul_a = g_rdata; mul_b = pcbs_pkg::sext32(cn);
        cw_en     = mul_done;
        cw_data   = pcbs_pkg::sat32(pcbs_pkg::sub_sat48(tmp, mul_y));
      end
      pcbs_pkg::S_W0: begin
        cw_en = 1'b1; cw_addr = '0; cw_data = cn;
      end
      pcbs_pkg::S_W1: begin
        cw_en = 1'b1; cw_addr = n + CW'(1); cw_data = c1;
      end
      pcbs_pkg::S_W2: begin
        cw_en = 1'b1; cw_addr = n + CW'(2); cw_data = c2;
      end
      default: ;
    endcase
  end

  assign mul_start = mul_state && !op_wait;
  assign div_start = div_state && !op_wait;

  // rhs write port: loads when idle, solver write-back otherwise
  assign rhs_we    = load_fire || sw_we;
  assign rhs_waddr = load_fire ? lc[AW-1:0] : row;
  assign rhs_wdata = load_fire ? pcbs_pkg::sext32(s_axis_tdata[31:0]) : sw_d;

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= pcbs_pkg::S_IDLE;
      op_wait       <= 1'b0;
      interpolate   <= 1'b1;
      sample_count  <= 11'd16;
      lc            <= '0;
      solved        <= 1'b0;
      q1_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;

      if (mul_start || div_start)   op_wait <= 1'b1;
      else if (mul_done || div_done) op_wait <= 1'b0;

      if (cfg_wr) begin
        if (paddr[2] == pcbs_pkg::REG_INTERPOLATE) interpolate  <= pwdata[0];
        else                                       sample_count <= pwdata[10:0];
        lc     <= '0;
        solved <= 1'b0;
      end else begin
        if (load_fire) begin
          lc <= last_sample ? '0 : lc_inc;
          if (lc == '0) solved <= 1'b0;
        end
        if (state == pcbs_pkg::S_W2) solved <= 1'b1;
      end

      if (read_fire)                 q1_valid <= 1'b1;
      else if (q1_valid && out_free) q1_valid <= 1'b0;

      if (q1_valid && out_free) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready)   m_axis_tvalid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (read_fire) begin
      q1_ok     <= idx_x <= (XW'(n) + XW'(2));
      q1_solved <= solved;
    end
    if (q1_valid && out_free) begin
      m_axis_tdata <= (q1_ok && q1_solved) ? cf_rdata : 32'd0;
      m_axis_tuser <= {q1_ok, q1_solved};
    end

    // wrap sources, caught as they are written
    if (cw_en) begin
      if (cw_addr == CW'(1)) c1 <= cw_data;
      if (cw_addr == CW'(2)) c2 <= cw_data;
      if (cw_addr == n)      cn <= cw_data;
    end

    case (state)
      pcbs_pkg::S_IDLE:  row <= '0;
      pcbs_pkg::S_CP_WR: row <= row + AW'(1);
      pcbs_pkg::S_IN_S0: if (mul_done) pd <= mul_y;
      pcbs_pkg::S_IN_W0: begin
        pm <= pcbs_pkg::K_RATIO;
        pg <= pcbs_pkg::K_RATIO;
      end
      pcbs_pkg::S_IN_SL:
        if (mul_done) begin
          d_last <= mul_y;
          m_last <= pcbs_pkg::K_RATIO;
          g_last <= pcbs_pkg::K_ONE;
          row    <= AW'(1);
        end
      pcbs_pkg::S_F_M0:  if (mul_done) ds <= mul_y;
      pcbs_pkg::S_F_M1:  if (mul_done) tmp <= pcbs_pkg::sub_sat48(pcbs_pkg::K_ONE, mul_y);
      pcbs_pkg::S_F_DIV: if (div_done) inv <= div_y;
      pcbs_pkg::S_F_M2:  if (mul_done) tmp <= mul_y;
      pcbs_pkg::S_F_M3:  if (mul_done) ng <= mul_y;
      pcbs_pkg::S_F_M4:  if (mul_done) nm <= mul_y;
      pcbs_pkg::S_F_M5:  if (mul_done) tmp <= mul_y;
      pcbs_pkg::S_F_M6:  if (mul_done) nd <= mul_y;
      pcbs_pkg::S_F_M7:  if (mul_done) d_last <= pcbs_pkg::sub_sat48(d_last, mul_y);
      pcbs_pkg::S_F_M8:  if (mul_done) g_last <= pcbs_pkg::sub_sat48(g_last, mul_y);
      pcbs_pkg::S_F_M9:
        if (mul_done) begin
          m_last <= pcbs_pkg::sub_sat48('0, mul_y);
          pm     <= nm;
          pg     <= ng;
          pd     <= nd;
          row    <= row + AW'(1);
        end
      pcbs_pkg::S_P_A:   m_last <= pcbs_pkg::add_sat48(m_last, pcbs_pkg::K_RATIO);
      pcbs_pkg::S_P_M1:  if (mul_done) g_last <= pcbs_pkg::sub_sat48(g_last, mul_y);
      pcbs_pkg::S_P_M2:  if (mul_done) d_last <= pcbs_pkg::sub_sat48(d_last, mul_y);
      pcbs_pkg::S_P_DIV: if (div_done) inv <= div_y;
      pcbs_pkg::S_P_M3:
        if (mul_done) begin
          prev <= pcbs_pkg::sext32(pcbs_pkg::sat32(mul_y));
          row  <= n_m2[AW-1:0];
        end
      pcbs_pkg::S_B_M1:
        if (mul_done) tmp <= pcbs_pkg::sub_sat48(rhs_rdata, mul_y);
      pcbs_pkg::S_B_M2:
        if (mul_done) begin
          prev <= pcbs_pkg::sext32(cw_data);
          if (row != '0) row <= row - AW'(1);
        end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Arithmetic units and state memories
  // ---------------------------------------------------------------------------
  pcbs_mulq u_mulq (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .y     (mul_y)
  );

  pcbs_recip u_recip (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .x     (div_x),
    .done  (div_done),
    .y     (div_y)
  );

  pcbs_ram #(.WIDTH(pcbs_pkg::VAL_W), .DEPTH(MAX_POINTS)) u_rhs_ram (
    .clk   (clk),
    .we    (rhs_we),
    .waddr (rhs_waddr),
    .wdata (rhs_wdata),
    .re    (rhs_re),
    .raddr (rhs_raddr),
    .rdata (rhs_rdata)
  );

  pcbs_ram #(.WIDTH(pcbs_pkg::VAL_W), .DEPTH(MAX_POINTS)) u_mu_ram (
    .clk   (clk),
    .we    (sw_we),
    .waddr (row),
    .wdata (sw_m),
    .re    (mg_re),
    .raddr (row),
    .rdata (mu_rdata)
  );

  pcbs_ram #(.WIDTH(pcbs_pkg::VAL_W), .DEPTH(MAX_POINTS)) u_gamma_ram (
    .clk   (clk),
    .we    (sw_we),
    .waddr (row),
    .wdata (sw_g),
    .re    (mg_re),
    .raddr (row),
    .rdata (g_rdata)
  );

  pcbs_ram #(.WIDTH(pcbs_pkg::COEF_W), .DEPTH(CDEPTH)) u_coeff_ram (
    .clk   (clk),
    .we    (cw_en),
    .waddr (cw_addr),
    .wdata (cw_data),
    .re    (cf_re),
    .raddr (cf_raddr),
    .rdata (cf_rdata)
  );

endmodule

### rtl/core/pcbs_ram.sv
// ============================================================================
// pcbs_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ============================================================================
module pcbs_ram #(
  parameter int WIDTH = pcbs_pkg::COEF_W,
  parameter int DEPTH = pcbs_pkg::MAX_POINTS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];   // holds when not read
  end

endmodule

### rtl/core/pcbs_mulq.sv
// ============================================================================
// pcbs_mulq
// 48x48 signed Q.30 multiply, rounded half away from zero, saturated to
// 48 bits. Four 24x24 partial products, one per cycle.
// ============================================================================
module pcbs_mulq (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  pcbs_pkg::val_t   a,
  input  pcbs_pkg::val_t   b,
  output logic             done,
  output pcbs_pkg::val_t   y
);

  logic [47:0] ua, ub, ma, mb;
  logic        neg;
  logic        busy;
  logic [2:0]  k;
  logic [47:0] pp;
  logic [1:0]  ps;
  logic [95:0] acc;
  logic [95:0] pp_sh;
  logic [65:0] q;
  logic        pos_ovf, neg_ovf;
  pcbs_pkg::val_t res;

  assign ua = a;
  assign ub = b;

  always_comb begin
    case (ps)
      2'd0:    pp_sh = {48'b0, pp};
      2'd1:    pp_sh = {24'b0, pp, 24'b0};
      2'd2:    pp_sh = {pp, 48'b0};
      default: pp_sh = '0;
    endcase
  end

  // acc already carries the rounding half
  assign q       = acc[95:pcbs_pkg::CF];
  assign pos_ovf = |q[65:47];
  assign neg_ovf = (|q[65:48]) || (q[47] && (|q[46:0]));

  always_comb begin
    if (neg) res = neg_ovf ? pcbs_pkg::MIN48 : pcbs_pkg::val_t'(~q[47:0] + 48'd1);
    else     res = pos_ovf ? pcbs_pkg::MAX48 : pcbs_pkg::val_t'(q[47:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else begin
      done <= !start && busy && (k == 3'd5);
      if (start) begin
        busy <= 1'b1;
        k    <= '0;
      end else if (busy) begin
        k <= k + 3'd1;
        if (k == 3'd5) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= ua[47] ? (~ua + 48'd1) : ua;
      mb  <= ub[47] ? (~ub + 48'd1) : ub;
      neg <= ua[47] ^ ub[47];
      acc <= 96'd1 << (pcbs_pkg::CF - 1);
    end else if (busy) begin
      if (k < 3'd4) begin
        pp <= 48'(ma[24*k[1] +: 24] * mb[24*k[0] +: 24]);
        ps <= 2'(k[1]) + 2'(k[0]);
      end
      if (k >= 3'd1 && k <= 3'd4) acc <= acc + pp_sh;
      if (k == 3'd5) y <= res;
    end
  end

endmodule

### rtl/core/pcbs_recip.sv
// ============================================================================
// pcbs_recip
// Reciprocal 2^60 / x, truncated toward zero, saturated to 48 bits.
// Restoring division, one quotient bit per cycle.
// ============================================================================
module pcbs_recip (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  pcbs_pkg::val_t   x,
  output logic             done,
  output pcbs_pkg::val_t   y
);

  localparam int QW   = pcbs_pkg::RECIP_STEPS;
  localparam int CNTW = $clog2(QW);

  logic [47:0]     ux, mag;
  logic            neg, zero;
  logic [48:0]     rem, r2, rn;
  logic [QW-1:0]   q;
  logic [CNTW-1:0] cnt;
  logic            busy, fin;
  logic            ge, pos_ovf, neg_ovf;
  pcbs_pkg::val_t  res;

  assign ux = x;

  // the dividend has a single one, at its top bit
  assign r2 = {rem[47:0], (cnt == CNTW'(QW - 1))};
  assign ge = r2 >= {1'b0, mag};
  assign rn = ge ? (r2 - {1'b0, mag}) : r2;

  assign pos_ovf = |q[QW-1:47];
  assign neg_ovf = (|q[QW-1:48]) || (q[47] && (|q[46:0]));

  always_comb begin
    if (zero)     res = pcbs_pkg::MAX48;
    else if (neg) res = neg_ovf ? pcbs_pkg::MIN48 : pcbs_pkg::val_t'(~q[47:0] + 48'd1);
    else          res = pos_ovf ? pcbs_pkg::MAX48 : pcbs_pkg::val_t'(q[47:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && fin;
      if (start) begin
        busy <= 1'b1;
        fin  <= 1'b0;
      end else if (busy) begin
        if (fin) begin
          busy <= 1'b0;
          fin  <= 1'b0;
        end else if (cnt == '0) begin
          fin <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag  <= ux[47] ? (~ux + 48'd1) : ux;
      neg  <= ux[47];
      zero <= (ux == '0);
      rem  <= '0;
      q    <= '0;
      cnt  <= CNTW'(QW - 1);
    end else if (busy) begin
      if (!fin) begin
        rem <= rn;
        q   <= {q[QW-2:0], ge};
        cnt <= cnt - CNTW'(1);
      end else begin
        y <= res;
      end
    end
  end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: periodic cubic B-spline solver testbench
// Stream and register-port stimulus with its own fixed-point prediction of
// the coefficient solve. Read results are checked field by field, in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int      WATCHDOG_LIMIT = 1000000;
  localparam int      RAND_ITEMS     = 600;
  localparam longint  Q_MAX          = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint  Q_MIN          = -Q_MAX - 1;

  typedef struct {
    logic        mode;
    logic [31:0] sample;
    logic [10:0] index;
  } stim_t;

  typedef struct {
    logic [31:0] coef;
    logic        rdy;
    logic        ok;
  } coef_rd_t;

  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;   // [31:0] sample, [42:32] index, rest zero
  logic [0:0]  s_axis_tuser  = '0;   // [0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [31:0] coefficient
  logic [1:0]  m_axis_tuser;         // [0] ready_res, [1] index_ok
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  periodic_cubic_bspline_solver uut (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // --------------------------------------------------------------------------
  // Shadow of the block: registers, load progress and the four stores
  // --------------------------------------------------------------------------
  bit          sh_interp = 1'b1;
  logic [10:0] sh_count  = 11'd16;
  int          sh_loaded = 0;
  bit          sh_solved = 1'b0;
  longint      rhs_q[pcbs_pkg::MAX_POINTS_DEF];
  longint      gam_q[pcbs_pkg::MAX_POINTS_DEF];
  longint      mu_q[pcbs_pkg::MAX_POINTS_DEF];
  longint      coef_q[pcbs_pkg::MAX_POINTS_DEF + 3];

  stim_t    pending_items[$];
  coef_rd_t coef_expected[$];
  int       errors    = 0;
  int       sent      = 0;
  int       res_count = 0;
  bit       took      = 1'b0;
  int       idle_cyc  = 0;

  function automatic longint clip48(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  // Q.30 product, rounded half away from zero, saturated to 48 bits
  function automatic longint qmul(longint a, longint b);
    logic signed [127:0] wa, wb, p;
    logic        [127:0] m;
    bit                  neg;
    wa = a;
    wb = b;
    p = wa * wb;
    neg = (p < 0);
    m = neg ? -p : p;
    m = (m + (128'd1 << 29)) >> 30;
    if (neg) return (m > 128'h8000_0000_0000) ? Q_MIN : -longint'(m[63:0]);
    return (m > 128'h7FFF_FFFF_FFFF) ? Q_MAX : longint'(m[63:0]);
  endfunction

  function automatic longint qrecip(longint x);
    logic signed [127:0] num, den, q;
    if (x == 0) return Q_MAX;
    num = 128'sd1 <<< 60;
    den = x;
    q = num / den;
    if (q > Q_MAX) return Q_MAX;
    if (q < Q_MIN) return Q_MIN;
    return longint'(q[63:0]);
  endfunction

  function automatic int points();
    if (sh_count < 3) return 3;
    if (sh_count > pcbs_pkg::MAX_POINTS_DEF) return pcbs_pkg::MAX_POINTS_DEF;
    return sh_count;
  endfunction

  // cyclic tridiagonal solve (or plain copy), then the three wrap coefficients
  function automatic void solve_set(int n);
    longint one, rat, inv, v;
    one = longint'(pcbs_pkg::K_ONE);
    rat = longint'(pcbs_pkg::K_RATIO);
    if (!sh_interp) begin
      for (int i = 0; i < n; i++) coef_q[i+1] = clip32(rhs_q[i]);
    end else begin
      for (int i = 0; i < n; i++) rhs_q[i] = qmul(rhs_q[i], longint'(pcbs_pkg::K_3HALF));
      gam_q[0] = rat;
      mu_q[0] = rat;
      mu_q[n-1] = rat;
      gam_q[n-1] = one;
      for (int r = 1; r + 1 < n; r++) begin
        inv = qrecip(clip48(one - qmul(mu_q[r-1], rat)));
        gam_q[r] = qmul(qmul(longint'(pcbs_pkg::K_NEG_RATIO), gam_q[r-1]), inv);
        mu_q[r] = qmul(inv, rat);
        rhs_q[r] = qmul(inv, clip48(rhs_q[r] - qmul(rat, rhs_q[r-1])));
        rhs_q[n-1] = clip48(rhs_q[n-1] - qmul(mu_q[n-1], rhs_q[r-1]));
        gam_q[n-1] = clip48(gam_q[n-1] - qmul(mu_q[n-1], gam_q[r-1]));
        mu_q[n-1] = clip48(0 - qmul(mu_q[n-1], mu_q[r-1]));
      end
      mu_q[n-1] = clip48(mu_q[n-1] + rat);
      gam_q[n-1] = clip48(gam_q[n-1]
                   - qmul(mu_q[n-1], clip48(mu_q[n-2] + gam_q[n-2])));
      rhs_q[n-1] = clip48(rhs_q[n-1] - qmul(mu_q[n-1], rhs_q[n-2]));
      coef_q[n] = clip32(qmul(rhs_q[n-1], qrecip(gam_q[n-1])));
      for (int r = n - 2; r >= 0; r--) begin
        v = clip48(rhs_q[r] - qmul(mu_q[r], coef_q[r+2]));
        coef_q[r+1] = clip32(clip48(v - qmul(gam_q[r], coef_q[n])));
      end
    end
    coef_q[0] = coef_q[n];
    coef_q[n+1] = coef_q[1];
    coef_q[n+2] = coef_q[2];
  endfunction

  // apply one accepted input transaction to the shadow
  function automatic void predict_item(logic mode, logic [31:0] smp, logic [10:0] idx);
    int       n;
    coef_rd_t e;
    n = points();
    if (mode == pcbs_pkg::MODE_LOAD) begin
      if (sh_loaded == 0) sh_solved = 1'b0;
      rhs_q[sh_loaded] = longint'($signed(smp));
      sh_loaded++;
      if (sh_loaded >= n) begin
        solve_set(n);
        sh_solved = 1'b1;
        sh_loaded = 0;
      end
    end else begin
      e.ok = (idx <= n + 2);
      e.rdy = sh_solved;
      e.coef = (e.ok && sh_solved) ? coef_q[idx][31:0] : 32'd0;
      coef_expected.push_back(e);
    end
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  // --------------------------------------------------------------------------
  // Input driver: changes at the falling edge, idles by segment of the run
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    stim_t nx;
    int    gap;
    gap = (sent < 560) ? 29 : (sent < 1120) ? 68 : 0;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || took) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= gap) begin
        nx = pending_items.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'b0, nx.index, nx.sample};
        s_axis_tuser <= nx.mode;
        sent++;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(negedge clk) begin
    int gap;
    gap = (sent < 560) ? 68 : (sent < 1120) ? 29 : 0;
    if (!hold_done && res_count >= 60) begin
      hold_done = 1'b1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= gap);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: input transactions feed the shadow, results checked in order
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    coef_rd_t e;
    bit       busy;
    busy = 1'b0;
    took = 1'b0;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      took = 1'b1;
      busy = 1'b1;
      predict_item(s_axis_tuser[0], s_axis_tdata[31:0], s_axis_tdata[42:32]);
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      busy = 1'b1;
      res_count++;
      if (coef_expected.size() == 0) begin
        report("unexpected result", m_axis_tdata, 32'd0);
      end else begin
        e = coef_expected.pop_front();
        if (m_axis_tdata !== e.coef) report("coefficient", m_axis_tdata, e.coef);
        if (m_axis_tuser[0] !== e.rdy)
          report("ready_res", 32'(m_axis_tuser[0]), 32'(e.rdy));
        if (m_axis_tuser[1] !== e.ok)
          report("index_ok", 32'(m_axis_tuser[1]), 32'(e.ok));
      end
    end
    if (psel && penable) busy = 1'b1;
    idle_cyc = busy ? 0 : idle_cyc + 1;
    if (idle_cyc >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic void put_load(logic [31:0] smp);
    stim_t it;
    it.mode = pcbs_pkg::MODE_LOAD;
    it.sample = smp;
    it.index = 11'($urandom);   // ignored on a load
    pending_items.push_back(it);
  endfunction

  function automatic void put_read(logic [10:0] idx);
    stim_t it;
    it.mode = pcbs_pkg::MODE_READ;
    it.sample = $urandom;       // ignored on a read
    it.index = idx;
    pending_items.push_back(it);
  endfunction

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1: return 32'($signed($urandom_range(2_000_000)) - 1_000_000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [10:0] pick_index(int n);
    if ($urandom_range(99) < 85) return 11'($urandom_range(n + 2));
    return 11'($urandom_range(2047));
  endfunction

  // wait until every item is in and every result is out; the final read of a
  // phase sits behind any solve, so an empty expectation queue means idle
  task automatic drain();
    do @(negedge clk);
    while (pending_items.size() > 0 || s_axis_tvalid || coef_expected.size() > 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic reg_write(logic sel, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == pcbs_pkg::REG_INTERPOLATE) sh_interp = val[0];
    else sh_count = val[10:0];
    sh_loaded = 0;
    sh_solved = 1'b0;
  endtask

  task automatic configure(bit interp, logic [10:0] cnt);
    if ($urandom_range(1)) begin
      reg_write(pcbs_pkg::REG_INTERPOLATE, {$urandom} & 32'hFFFF_FFFE | interp);
      reg_write(pcbs_pkg::REG_SAMPLE_COUNT, {21'd0, cnt});
    end else begin
      reg_write(pcbs_pkg::REG_SAMPLE_COUNT, {21'd0, cnt});
      reg_write(pcbs_pkg::REG_INTERPOLATE, {31'd0, interp});
    end
  endtask

  initial begin
    int n, rand_done, sets, loads, r;
    bit interp;
    logic [10:0] cnt;
    for (int i = 0; i < pcbs_pkg::MAX_POINTS_DEF + 3; i++) coef_q[i] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: smallest set, extremes, out-of-range reads, new set
    configure(1'b1, 11'd3);
    put_read(11'd0);                         // read before any solve
    put_load(32'h7FFF_FFFF);
    put_load(32'h8000_0000);
    put_read(11'd1);                         // mid-set read
    put_load(32'h0001_0000);
    for (int i = 0; i <= 6; i++) put_read(11'(i));
    put_read(11'd2047);
    put_load(32'h0000_0000);                 // first of a new set clears ready
    put_read(11'd1);
    drain();
    configure(1'b0, 11'd0);                  // count below range, copy mode
    put_load(32'h8000_0000);
    put_load(32'hFFFF_FFFF);
    put_load(32'h7FFF_FFFF);
    put_read(11'd0);
    put_read(11'd5);
    put_read(11'd6);
    drain();

    // largest set: over-range count clamps to the full store, one full solve
    configure(1'b1, 11'd2047);
    for (int i = 0; i < pcbs_pkg::MAX_POINTS_DEF; i++) put_load(pick_sample());
    for (int i = 0; i < 6; i++) put_read(pick_index(pcbs_pkg::MAX_POINTS_DEF));
    put_read(11'd1026);
    put_read(11'd1027);
    drain();

    // random phases: mostly complete sets of random content
    rand_done = 0;
    while (rand_done < RAND_ITEMS) begin
      interp = $urandom_range(1);
      r = $urandom_range(99);
      if (r < 80) cnt = 11'($urandom_range(3, 24));
      else if (r < 88) cnt = 11'($urandom_range(2));
      else if (r < 94) cnt = 11'($urandom_range(25, 64));
      else cnt = 11'($urandom_range(3, 24));
      configure(interp, cnt);
      n = points();
      sets = $urandom_range(1, 3);
      for (int s = 0; s < sets; s++) begin
        loads = ($urandom_range(9) == 0) ? $urandom_range(n - 1) : n;
        for (int i = 0; i < loads; i++) begin
          if ($urandom_range(3) == 0) begin
            put_read(pick_index(n));
            rand_done++;
          end
          put_load(pick_sample());
          rand_done++;
        end
        for (int i = $urandom_range(1, 6); i > 0; i--) begin
          put_read(pick_index(n));
          rand_done++;
        end
        if (loads < n) break;                // partial set: rewrite registers
      end
      put_read(pick_index(n));
      rand_done++;
      drain();
    end

    drain();
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
